// ===== design/srp_pkg.sv =====
// ----------------------------------------------------------------------------
// S-record parser package
// Shared types, character codes and digit helpers for the S-record parser.
// ----------------------------------------------------------------------------
`default_nettype none

package srp_pkg;

    localparam logic [7:0] CHAR_S    = 8'd83;
    localparam logic [7:0] CHAR_1    = 8'd49;
    localparam logic [7:0] CHAR_3    = 8'd51;
    localparam logic [7:0] CHAR_0    = 8'd48;
    localparam logic [7:0] CHAR_9    = 8'd57;
    localparam logic [7:0] CHAR_A    = 8'd65;
    localparam logic [7:0] CHAR_F    = 8'd70;
    localparam logic [7:0] ALPHA_OFS = 8'd55;
    localparam logic [7:0] BAD_DIGIT = 8'd255;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_TYPE   = 3'd1,
        PH_CNT_HI = 3'd2,
        PH_CNT_LO = 3'd3,
        PH_ADDR   = 3'd4,
        PH_DATA   = 3'd5
    } t_phase;

    typedef struct packed {
        logic        valid;
        logic [31:0] addr;
        logic [31:0] data;
    } t_result;

    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CHAR_0 && c <= CHAR_9) begin
            v = c - CHAR_0;
        end else if (c >= CHAR_A && c <= CHAR_F) begin
            v = c - ALPHA_OFS;
        end else begin
            v = BAD_DIGIT;
        end
        return v;
    endfunction

    // Bit position of each digit within a little-endian word, high digit first.
    function automatic logic [4:0] nibble_shift(input logic [2:0] idx);
        logic [4:0] s;
        unique case (idx)
            3'd0: s = 5'd4;
            3'd1: s = 5'd0;
            3'd2: s = 5'd12;
            3'd3: s = 5'd8;
            3'd4: s = 5'd20;
            3'd5: s = 5'd16;
            3'd6: s = 5'd28;
            3'd7: s = 5'd24;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== design/srp_parser_core.sv =====
// ----------------------------------------------------------------------------
// S-record parser core
// Record state registers and the per-character update logic.
// ----------------------------------------------------------------------------
`default_nettype none

module srp_parser_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic [7:0]      i_char,
    output srp_pkg::t_result     o_res
);

    srp_pkg::t_phase r_phase, n_phase;
    logic [2:0]  r_alen, n_alen;
    logic [7:0]  r_rbc, n_rbc;
    logic [7:0]  r_dbt, n_dbt;
    logic [31:0] r_base, n_base;
    logic [3:0]  r_adi, n_adi;
    logic [3:0]  r_wdi, n_wdi;
    logic [8:0]  r_ddc, n_ddc;
    logic [31:0] r_acc, n_acc;

    logic [7:0]  h;
    logic [31:0] h32;
    logic [5:0]  addr_sh;
    logic [3:0]  adi_inc;
    logic [7:0]  rbc_sum;
    logic [8:0]  ddc_inc;
    logic [8:0]  ddc_m1;
    logic [3:0]  wdi_inc;
    logic [2:0]  wdi_idx;
    logic [31:0] acc_sum;
    logic [31:0] word_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= srp_pkg::PH_IDLE;
            r_alen  <= '0;
            r_rbc   <= '0;
            r_dbt   <= '0;
            r_base  <= '0;
            r_adi   <= '0;
            r_wdi   <= '0;
            r_ddc   <= '0;
            r_acc   <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_alen  <= n_alen;
            r_rbc   <= n_rbc;
            r_dbt   <= n_dbt;
            r_base  <= n_base;
            r_adi   <= n_adi;
            r_wdi   <= n_wdi;
            r_ddc   <= n_ddc;
            r_acc   <= n_acc;
        end
    end

    always_comb begin
        h         = srp_pkg::hex_value(i_char);
        h32       = {24'd0, h};
        addr_sh   = {r_alen, 3'b000} - {r_adi, 2'b00};
        adi_inc   = r_adi + 4'd1;
        rbc_sum   = r_rbc + h;
        ddc_inc   = r_ddc + 9'd1;
        ddc_m1    = ddc_inc - 9'd1;
        wdi_inc   = r_wdi + 4'd1;
        wdi_idx   = 3'(r_wdi - 4'd1);
        acc_sum   = r_acc + (h32 << srp_pkg::nibble_shift(wdi_idx));
        word_addr = r_base + {24'd0, ddc_m1[8:3], 2'b00};

        n_phase = r_phase;
        n_alen  = r_alen;
        n_rbc   = r_rbc;
        n_dbt   = r_dbt;
        n_base  = r_base;
        n_adi   = r_adi;
        n_wdi   = r_wdi;
        n_ddc   = r_ddc;
        n_acc   = r_acc;
        o_res   = '{valid: 1'b0, addr: word_addr, data: acc_sum};

        if (i_char == srp_pkg::CHAR_S) begin
            n_phase = srp_pkg::PH_TYPE;
            n_alen  = '0;
            n_rbc   = '0;
            n_dbt   = '0;
            n_base  = '0;
            n_adi   = '0;
            n_wdi   = '0;
            n_ddc   = '0;
            n_acc   = '0;
        end else begin
            unique case (r_phase)
                srp_pkg::PH_TYPE: begin
                    if (i_char >= srp_pkg::CHAR_1 && i_char <= srp_pkg::CHAR_3) begin
                        n_alen  = 3'(i_char - srp_pkg::CHAR_0 + 8'd1);
                        n_phase = srp_pkg::PH_CNT_HI;
                    end else begin
                        n_phase = srp_pkg::PH_IDLE;
                    end
                end
                srp_pkg::PH_CNT_HI: begin
                    n_rbc   = {h[3:0], 4'd0};
                    n_phase = srp_pkg::PH_CNT_LO;
                end
                srp_pkg::PH_CNT_LO: begin
                    n_rbc  = rbc_sum;
                    n_base = '0;
                    if ({1'b0, rbc_sum} > {6'd0, r_alen} + 9'd1) begin
                        n_dbt = rbc_sum - 8'd1 - {5'd0, r_alen};
                    end else begin
                        n_dbt = '0;
                    end
                    n_adi   = 4'd1;
                    n_phase = srp_pkg::PH_ADDR;
                end
                srp_pkg::PH_ADDR: begin
                    n_base = r_base + (h32 << addr_sh[4:0]);
                    n_adi  = adi_inc;
                    if (adi_inc == {r_alen, 1'b1}) begin
                        n_adi = '0;
                        if (r_dbt == 8'd0) begin
                            n_phase = srp_pkg::PH_IDLE;
                        end else begin
                            n_phase = srp_pkg::PH_DATA;
                            n_wdi   = 4'd1;
                            n_ddc   = '0;
                            n_acc   = '0;
                        end
                    end
                end
                srp_pkg::PH_DATA: begin
                    n_acc = acc_sum;
                    n_wdi = wdi_inc;
                    n_ddc = ddc_inc;
                    if (ddc_inc >= {r_dbt, 1'b0}) begin
                        o_res.valid = 1'b1;
                        n_phase     = srp_pkg::PH_IDLE;
                        n_wdi       = '0;
                        n_ddc       = '0;
                        n_acc       = '0;
                    end else if (wdi_inc > 4'd8) begin
                        o_res.valid = 1'b1;
                        n_wdi       = 4'd1;
                        n_acc       = '0;
                    end
                end
                default: begin
                    n_phase = srp_pkg::PH_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/srp_out_reg.sv =====
// ----------------------------------------------------------------------------
// S-record parser output register
// Holds one finished word until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module srp_out_reg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  wire srp_pkg::t_result i_res,
    input  wire logic            i_stall,
    output logic                 o_valid,
    output logic [31:0]          o_word_address,
    output logic [31:0]          o_word_data
);

    logic        r_valid;
    logic [31:0] r_addr;
    logic [31:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_res.valid;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_res.valid) begin
            r_addr <= i_res.addr;
            r_data <= i_res.data;
        end
    end

    assign o_valid        = r_valid;
    assign o_word_address = r_addr;
    assign o_word_data    = r_data;

endmodule

`default_nettype wire

// ===== design/srecord_char_parser.sv =====
// ----------------------------------------------------------------------------
// S-record character parser
// Follows S1/S2/S3 records one character per item and emits 32-bit words
// with their byte addresses.
//
// Input channel: i_valid, i_rx_char, o_stall. One character is accepted at
// each edge where i_valid is high and o_stall is low.
// Output channel: o_valid, o_word_address, o_word_data, i_stall. A word is
// taken at each edge where o_valid is high and i_stall is low.
// Throughput is one character per cycle while the output is not stalled. An
// accepted character is held in the input register until the parser advances
// and is then parsed into the output register, where any resulting word appears.
// While the output register holds a word and i_stall is high, the parser
// does not advance; the input register still takes one more character if it
// is empty, and then o_stall rises until the word is taken.
// Synchronous reset clears the record state and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module srecord_char_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [7:0]  i_rx_char,
    output logic             o_stall,
    output logic             o_valid,
    output logic [31:0]      o_word_address,
    output logic [31:0]      o_word_data,
    input  wire logic        i_stall
);

    logic             r_in_valid;
    logic [7:0]       r_in_char;
    logic             advance;
    logic             in_take;
    srp_pkg::t_result core_res;

    assign advance = r_in_valid && (!o_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_char <= i_rx_char;
        end
    end

    srp_parser_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_char  (r_in_char),
        .o_res   (core_res)
    );

    srp_out_reg u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (advance),
        .i_res          (core_res),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_word_address (o_word_address),
        .o_word_data    (o_word_data)
    );

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && o_valid && i_stall))
        else $error("input stalled without a blocked item");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("reset did not empty the pipeline");

    a_word_only_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || !i_stall) && !r_in_valid |=> !o_valid)
        else $error("word appeared without a parsed item");

endmodule

`default_nettype wire
